// ===== hdl/neural_activation_unit_core_macros.svh =====
// Assertion macros for the activation unit.
`ifndef NEURAL_ACTIVATION_UNIT_CORE_MACROS_SVH
`define NEURAL_ACTIVATION_UNIT_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define NAU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define NAU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define NAU_ASSERT_IMP(lbl, ante, cons, msg)
`define NAU_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hdl/nau_pkg.sv =====
package nau_pkg;

  localparam int SIG_SEGMENTS = 64;
  localparam int SIG_IDX_W    = $clog2(SIG_SEGMENTS);
  localparam int SIG_FRAC_W   = 15 - SIG_IDX_W;
  localparam int ROM_W        = 16;
  localparam int PROD_W       = ROM_W + SIG_FRAC_W;
  localparam int PM_W         = 34;

  localparam logic [16:0]        S_ONE   = 17'd65536;
  localparam logic signed [15:0] Y_ONE   = 16'sd4096;
  localparam longint unsigned    Q31_ONE = 64'd2147483648;

  typedef enum logic [2:0] {
    FN_LINEAR,
    FN_RELU,
    FN_SIGMOID,
    FN_TANH,
    FN_DLINEAR,
    FN_DRELU,
    FN_DSIGMOID,
    FN_DTANH
  } nau_func_t;

  typedef logic [ROM_W-1:0] nau_rom_t [0:SIG_SEGMENTS];

  // Bit-serial unsigned division, evaluated only while the table is built.
  function automatic longint unsigned nau_udiv(input longint unsigned num,
                                               input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Entry k is sigmoid(8k/SIG_SEGMENTS) in unsigned Q0.16, from a Taylor
  // start for exp(-u/256) squared eight times.
  function automatic nau_rom_t nau_build_rom();
    nau_rom_t        rom;
    longint unsigned v;
    longint unsigned t;
    longint unsigned e;
    longint unsigned den;
    for (int k = 0; k <= SIG_SEGMENTS; k++) begin
      v = (64'(k) * 64'd67108864 + 64'(SIG_SEGMENTS / 2)) / SIG_SEGMENTS;
      t = v;
      e = Q31_ONE - t;
      t = ((t * v) >> 31) / 2;
      e = e + t;
      t = ((t * v) >> 31) / 3;
      e = e - t;
      t = ((t * v) >> 31) / 4;
      e = e + t;
      for (int n = 0; n < 8; n++) begin
        e = (e * e + 64'd1073741824) >> 31;
      end
      den    = Q31_ONE + e;
      rom[k] = ROM_W'(nau_udiv(64'd140737488355328 + (den >> 1), den));
    end
    return rom;
  endfunction

  localparam nau_rom_t SIG_ROM = nau_build_rom();

  typedef struct packed {
    nau_func_t                func;
    logic signed [15:0]       x;
    logic                     neg;
    logic                     sat;
    logic [ROM_W-1:0]         base;
    logic [ROM_W-1:0]         diff;
    logic [SIG_FRAC_W-1:0]    frac;
  } nau_s1_t;

  typedef struct packed {
    nau_func_t                func;
    logic signed [15:0]       x;
    logic                     neg;
    logic                     sat;
    logic [ROM_W-1:0]         base;
    logic [PROD_W-1:0]        prod;
  } nau_s2_t;

  typedef struct packed {
    nau_func_t                func;
    logic signed [15:0]       x;
    logic [16:0]              s;
  } nau_s3_t;

  typedef struct packed {
    nau_func_t                func;
    logic signed [15:0]       x;
    logic [16:0]              s;
    logic [PM_W-1:0]          pm;
  } nau_s4_t;

endpackage

// ===== hdl/nau_if.sv =====
interface nau_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic signed [15:0] x;

  modport source(output valid, output func, output x, input ready);
  modport sink(input valid, input func, input x, output ready);
endinterface

interface nau_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] y;
  logic               undefined;

  modport source(output valid, output y, output undefined, input ready);
  modport sink(input valid, input y, input undefined, output ready);
endinterface

// ===== hdl/nau_front.sv =====
module nau_front (
  input  logic            clk,
  input  logic            rst_n,
  nau_in_if.sink          in_ch,
  output logic            s1_vld,
  output nau_pkg::nau_s1_t s1,
  input  logic            s1_rdy
);

  logic                          vld_r;
  nau_pkg::nau_s1_t              s1_r;
  nau_pkg::nau_s1_t              s1_nxt;
  logic                          adv;
  nau_pkg::nau_func_t            fn;
  logic signed [17:0]            z;
  logic [17:0]                   a_w;
  logic [16:0]                   a;
  logic [nau_pkg::SIG_IDX_W-1:0] idx;
  logic [nau_pkg::SIG_IDX_W:0]   idx_hi;
  logic [nau_pkg::ROM_W-1:0]     next_v;

  assign adv         = !vld_r || s1_rdy;
  assign in_ch.ready = adv;

  always_comb begin
    fn = nau_pkg::nau_func_t'(in_ch.func);
    if (fn == nau_pkg::FN_TANH || fn == nau_pkg::FN_DTANH) begin
      z = {in_ch.x[15], in_ch.x, 1'b0};
    end else begin
      z = {{2{in_ch.x[15]}}, in_ch.x};
    end
    a_w    = z[17] ? 18'(-z) : 18'(z);
    a      = a_w[16:0];
    idx    = a[14 -: nau_pkg::SIG_IDX_W];
    idx_hi = {1'b0, idx} + 1'b1;
    next_v = nau_pkg::SIG_ROM[idx_hi];
    s1_nxt.func = fn;
    s1_nxt.x    = in_ch.x;
    s1_nxt.neg  = z[17];
    s1_nxt.sat  = a[16] | a[15];
    s1_nxt.base = nau_pkg::SIG_ROM[idx];
    s1_nxt.diff = next_v - nau_pkg::SIG_ROM[idx];
    s1_nxt.frac = a[nau_pkg::SIG_FRAC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_ch.valid) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1_vld = vld_r;
  assign s1     = s1_r;

endmodule

// ===== hdl/nau_interp.sv =====
module nau_interp (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             s1_vld,
  input  nau_pkg::nau_s1_t s1,
  output logic             s1_rdy,
  output logic             s3_vld,
  output nau_pkg::nau_s3_t s3,
  input  logic             s3_rdy
);

  logic                       s2_vld_r;
  logic                       s3_vld_r;
  nau_pkg::nau_s2_t           s2_r;
  nau_pkg::nau_s2_t           s2_nxt;
  nau_pkg::nau_s3_t           s3_r;
  nau_pkg::nau_s3_t           s3_nxt;
  logic                       adv2;
  logic                       adv3;
  logic [nau_pkg::PROD_W:0]   rnd;
  logic [15:0]                corr;
  logic [16:0]                spos;

  assign adv3   = !s3_vld_r || s3_rdy;
  assign adv2   = !s2_vld_r || adv3;
  assign s1_rdy = adv2;

  always_comb begin
    s2_nxt.func = s1.func;
    s2_nxt.x    = s1.x;
    s2_nxt.neg  = s1.neg;
    s2_nxt.sat  = s1.sat;
    s2_nxt.base = s1.base;
    s2_nxt.prod = nau_pkg::PROD_W'(s1.diff) * nau_pkg::PROD_W'(s1.frac);
  end

  // The interpolated step never exceeds the segment rise, so it fits 16 bits.
  always_comb begin
    rnd  = {1'b0, s2_r.prod} + (nau_pkg::PROD_W + 1)'(1 << (nau_pkg::SIG_FRAC_W - 1));
    corr = 16'(rnd >> nau_pkg::SIG_FRAC_W);
    spos = s2_r.sat ? nau_pkg::S_ONE : 17'(s2_r.base) + 17'(corr);
    s3_nxt.func = s2_r.func;
    s3_nxt.x    = s2_r.x;
    s3_nxt.s    = s2_r.neg ? nau_pkg::S_ONE - spos : spos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      if (adv2) begin
        s2_vld_r <= s1_vld;
      end
      if (adv3) begin
        s3_vld_r <= s2_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_vld) begin
      s2_r <= s2_nxt;
    end
    if (adv3 && s2_vld_r) begin
      s3_r <= s3_nxt;
    end
  end

  assign s3_vld = s3_vld_r;
  assign s3     = s3_r;

endmodule

// ===== hdl/nau_back.sv =====
module nau_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             s3_vld,
  input  nau_pkg::nau_s3_t s3,
  output logic             s3_rdy,
  nau_out_if.source        out_ch
);

  logic                     s4_vld_r;
  logic                     s5_vld_r;
  nau_pkg::nau_s4_t         s4_r;
  nau_pkg::nau_s4_t         s4_nxt;
  logic signed [15:0]       y_r;
  logic signed [15:0]       y_nxt;
  logic                     undef_r;
  logic                     undef_nxt;
  logic                     adv4;
  logic                     adv5;
  logic signed [18:0]       tt;
  logic [18:0]              tm;
  logic [16:0]              opa;
  logic [16:0]              opb;
  logic [17:0]              sg;
  logic [18:0]              tg;
  logic [nau_pkg::PM_W:0]   dg;
  logic [nau_pkg::PM_W:0]   dt;

  assign adv5   = !s5_vld_r || out_ch.ready;
  assign adv4   = !s4_vld_r || adv5;
  assign s3_rdy = adv4;

  // One multiplier serves both derivatives: s*(1-s) or t*t with t = 2s-1.
  always_comb begin
    tt = $signed({1'b0, s3.s, 1'b0}) - 19'sd65536;
    tm = tt[18] ? 19'(-tt) : 19'(tt);
    if (s3.func == nau_pkg::FN_DSIGMOID) begin
      opa = s3.s;
      opb = nau_pkg::S_ONE - s3.s;
    end else begin
      opa = tm[16:0];
      opb = tm[16:0];
    end
    s4_nxt.func = s3.func;
    s4_nxt.x    = s3.x;
    s4_nxt.s    = s3.s;
    s4_nxt.pm   = nau_pkg::PM_W'(opa) * nau_pkg::PM_W'(opb);
  end

  always_comb begin
    sg        = {1'b0, s4_r.s} + 18'd8;
    tg        = {1'b0, s4_r.s, 1'b0} + 19'd8;
    dg        = {1'b0, s4_r.pm} + 35'd524288;
    dt        = 35'h1_0000_0000 - {1'b0, s4_r.pm} + 35'd524288;
    undef_nxt = 1'b0;
    case (s4_r.func)
      nau_pkg::FN_LINEAR:   y_nxt = s4_r.x;
      nau_pkg::FN_RELU:     y_nxt = s4_r.x[15] ? 16'sd0 : s4_r.x;
      nau_pkg::FN_SIGMOID:  y_nxt = 16'(sg >> 4);
      nau_pkg::FN_TANH:     y_nxt = 16'(tg >> 4) - nau_pkg::Y_ONE;
      nau_pkg::FN_DLINEAR:  y_nxt = nau_pkg::Y_ONE;
      nau_pkg::FN_DRELU: begin
        if (s4_r.x == 16'sd0) begin
          y_nxt     = 16'sd0;
          undef_nxt = 1'b1;
        end else begin
          y_nxt = s4_r.x[15] ? 16'sd0 : nau_pkg::Y_ONE;
        end
      end
      nau_pkg::FN_DSIGMOID: y_nxt = 16'(dg >> 20);
      nau_pkg::FN_DTANH:    y_nxt = 16'(dt >> 20);
      default:              y_nxt = 16'sd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else begin
      if (adv4) begin
        s4_vld_r <= s3_vld;
      end
      if (adv5) begin
        s5_vld_r <= s4_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv4 && s3_vld) begin
      s4_r <= s4_nxt;
    end
    if (adv5 && s4_vld_r) begin
      y_r     <= y_nxt;
      undef_r <= undef_nxt;
    end
  end

  assign out_ch.valid     = s5_vld_r;
  assign out_ch.y         = y_r;
  assign out_ch.undefined = undef_r;

endmodule

// ===== hdl/neural_activation_unit_core.sv =====
// Element-wise activation unit for a streaming datapath.
// in_ch carries a function code and a signed Q4.12 operand; out_ch returns
// the signed Q4.12 result and a flag that marks the ReLU derivative taken at
// exactly zero. Both channels use valid/ready, and a transaction completes on
// a clock edge where both are high.
// The pipeline has five register stages: table lookup, segment multiply,
// interpolation, derivative multiply and the output register. A result
// passes through them in that order; a new input can be taken every cycle
// while out_ch.ready is high, so sustained throughput is one transaction
// per cycle.
// Each stage has its own valid bit and moves when the stage after it is
// empty or moving, so idle slots close up behind a stalled receiver.
// When out_ch.ready is low the output holds its transaction and the stages
// behind it fill; in_ch.ready falls only once all five stages are full.
// The synchronous reset clears every valid bit; no transaction is in flight
// afterward and the sigmoid table is constant, so no warm-up is needed.
`include "neural_activation_unit_core_macros.svh"

module neural_activation_unit_core (
  input  logic      clk,
  input  logic      rst_n,
  nau_in_if.sink    in_ch,
  nau_out_if.source out_ch
);

  logic             s1_vld;
  logic             s1_rdy;
  nau_pkg::nau_s1_t s1;
  logic             s3_vld;
  logic             s3_rdy;
  nau_pkg::nau_s3_t s3;

  nau_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .s1_vld (s1_vld),
    .s1     (s1),
    .s1_rdy (s1_rdy)
  );

  nau_interp u_interp (
    .clk    (clk),
    .rst_n  (rst_n),
    .s1_vld (s1_vld),
    .s1     (s1),
    .s1_rdy (s1_rdy),
    .s3_vld (s3_vld),
    .s3     (s3),
    .s3_rdy (s3_rdy)
  );

  nau_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .s3_vld (s3_vld),
    .s3     (s3),
    .s3_rdy (s3_rdy),
    .out_ch (out_ch)
  );

  `NAU_ASSERT_NXT(a_accept_loads_s1, in_ch.valid && in_ch.ready, s1_vld, "accepted input did not reach the lookup stage")
  `NAU_ASSERT_NXT(a_s1_hold, s1_vld && !s1_rdy, s1_vld && $stable(s1), "lookup stage changed while stalled")
  `NAU_ASSERT_NXT(a_s3_hold, s3_vld && !s3_rdy, s3_vld && $stable(s3), "interpolation stage changed while stalled")
  `NAU_ASSERT_IMP(a_undef_zero, out_ch.valid && out_ch.undefined, out_ch.y == 16'sd0, "undefined result with nonzero value")

endmodule
